// ----- design/clr_pkg.sv -----
`default_nettype none
package clr_pkg;

	// screen limits
	localparam int DIM_W = 13;
	localparam int PIX_W = 12;
	localparam int DEC_W = 16;
	localparam logic [DIM_W-1:0] SCREEN_MAX = 13'd4096;
	localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// outcodes, one bit each
	localparam logic [3:0] OC_NONE = 4'd0;
	localparam logic [3:0] OC_TOP = 4'd8;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_RIGHT = 4'd2;
	localparam logic [3:0] OC_LEFT = 4'd1;

	localparam logic [4:0] CLIP_PASSES = 5'd16;

	// register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef enum logic [2:0] {
		MODE_HORIZ = 3'd0,
		MODE_VERT = 3'd1,
		MODE_DIAG = 3'd2,
		MODE_XMAJOR = 3'd3,
		MODE_YMAJOR = 3'd4
	} clr_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_CLIP
	} clr_state_t;

	typedef enum logic [2:0] {
		CL_IDLE,
		CL_EVAL,
		CL_MUL,
		CL_DIVGO,
		CL_DIVW,
		CL_UPD
	} clr_clip_state_t;

	// clip engine status toward the top level
	typedef struct packed {
		logic done;
		logic visible;
	} clr_clip_res_t;

endpackage
`default_nettype wire

// ----- design/clr_div.sv -----
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module clr_div #(
	parameter int DW = 17
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [2*DW-1:0] numer,
	input  wire logic [DW-1:0]   denom,
	output logic                 done,
	output logic [2*DW-1:0]      quot
);

	localparam int NW = 2 * DW;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;

	// trial subtract of the shifted remainder
	assign shifted = {rem_q, num_q[NW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end else if (start) begin
			rem_q <= '0;
			num_q <= numer;
			den_q <= denom;
		end
	end

	// full-width quotient, the numerator register holds it after the last shift
	assign done = done_q;
	assign quot = num_q;

endmodule
`default_nettype wire

// ----- design/clr_clip.sv -----
`default_nettype none
// Cohen-Sutherland clip sequencer over one multiplier and one divider.
module clr_clip #(
	parameter int CXW = 18
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [CXW-1:0]         in_x0,
	input  wire logic signed [CXW-1:0]         in_y0,
	input  wire logic signed [CXW-1:0]         in_x1,
	input  wire logic signed [CXW-1:0]         in_y1,
	input  wire logic [clr_pkg::DIM_W-1:0]     dim_w,
	input  wire logic [clr_pkg::DIM_W-1:0]     dim_h,
	output clr_pkg::clr_clip_res_t             res,
	output logic [clr_pkg::DIM_W-1:0]          cx0,
	output logic [clr_pkg::DIM_W-1:0]          cy0,
	output logic [clr_pkg::DIM_W-1:0]          cx1,
	output logic [clr_pkg::DIM_W-1:0]          cy1
);

	localparam int MW = CXW - 1;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 2;
	localparam logic signed [63:0] LIM = 64'sd1073741824;

	clr_pkg::clr_clip_state_t state_q, state_d;

	logic signed [CXW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [4:0]            pass_q;
	logic                  sel0_q;
	logic                  use_y_q;
	logic signed [CXW-1:0] fixed_q;
	logic signed [CXW-1:0] base_q;
	logic                  neg_q;
	logic [MW-1:0]         a_mag_q, b_mag_q, d_mag_q;
	logic [PW-1:0]         prod_q;

	logic [3:0]            c0, c1, oc;
	logic                  use_y;
	logic signed [CXW-1:0] wx, hx, fixed, den, a_v, b_v, base;
	logic                  ev_accept, ev_reject;
	logic                  div_start, div_done;
	logic [PW-1:0]         quo;
	logic signed [SW-1:0]  q_s, nsum;
	logic signed [CXW-1:0] nval, nx, ny;

	// clamp to plus or minus 2^30
	function automatic logic signed [CXW-1:0] sat_c(input logic signed [SW-1:0] v);
		if (v > SW'(LIM)) return CXW'(LIM);
		if (v < -SW'(LIM)) return -CXW'(LIM);
		return v[CXW-1:0];
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [CXW-1:0] v);
		logic signed [CXW-1:0] a;
		a = (v < 0) ? -v : v;
		return a[MW-1:0];
	endfunction

	function automatic logic [3:0] outcode(input logic signed [CXW-1:0] x,
			input logic signed [CXW-1:0] y, input logic signed [CXW-1:0] w,
			input logic signed [CXW-1:0] h);
		if (y > h) return clr_pkg::OC_TOP;
		if (y < 0) return clr_pkg::OC_BOTTOM;
		if (x > w) return clr_pkg::OC_RIGHT;
		if (x < 0) return clr_pkg::OC_LEFT;
		return clr_pkg::OC_NONE;
	endfunction

	// outcodes and intersection operands for this pass
	always_comb begin
		wx = $signed(CXW'(dim_w));
		hx = $signed(CXW'(dim_h));
		c0 = outcode(x0_q, y0_q, wx, hx);
		c1 = outcode(x1_q, y1_q, wx, hx);
		oc = (c0 != clr_pkg::OC_NONE) ? c0 : c1;
		use_y = (oc == clr_pkg::OC_TOP) || (oc == clr_pkg::OC_BOTTOM);
		if (use_y) begin
			fixed = (oc == clr_pkg::OC_TOP) ? hx : '0;
			den = y1_q - y0_q;
			a_v = x1_q - x0_q;
			b_v = fixed - y0_q;
			base = x0_q;
		end else begin
			fixed = (oc == clr_pkg::OC_RIGHT) ? wx : '0;
			den = x1_q - x0_q;
			a_v = y1_q - y0_q;
			b_v = fixed - x0_q;
			base = y0_q;
		end
		ev_accept = (pass_q != clr_pkg::CLIP_PASSES) && (c0 == clr_pkg::OC_NONE)
			&& (c1 == clr_pkg::OC_NONE);
		ev_reject = !ev_accept && ((pass_q == clr_pkg::CLIP_PASSES)
			|| ((c0 & c1) != clr_pkg::OC_NONE) || (den == 0));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clr_pkg::CL_IDLE:  if (start) state_d = clr_pkg::CL_EVAL;
			clr_pkg::CL_EVAL:  state_d = (ev_accept || ev_reject) ? clr_pkg::CL_IDLE
				: clr_pkg::CL_MUL;
			clr_pkg::CL_MUL:   state_d = clr_pkg::CL_DIVGO;
			clr_pkg::CL_DIVGO: state_d = clr_pkg::CL_DIVW;
			clr_pkg::CL_DIVW:  if (div_done) state_d = clr_pkg::CL_UPD;
			clr_pkg::CL_UPD:   state_d = clr_pkg::CL_EVAL;
			default:           state_d = clr_pkg::CL_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		res.done = 1'b0;
		res.visible = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			clr_pkg::CL_EVAL: begin
				res.done = ev_accept || ev_reject;
				res.visible = ev_accept;
			end
			clr_pkg::CL_DIVGO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= clr_pkg::CL_IDLE;
		else state_q <= state_d;
	end

	clr_div #(.DW(MW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (prod_q),
		.denom  (d_mag_q),
		.done   (div_done),
		.quot   (quo)
	);

	// new endpoint from the quotient
	always_comb begin
		q_s = $signed(SW'(quo));
		if (neg_q) q_s = -q_s;
		nsum = SW'(base_q) + q_s;
		nval = sat_c(nsum);
		nx = use_y_q ? nval : fixed_q;
		ny = use_y_q ? fixed_q : nval;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			clr_pkg::CL_IDLE: begin
				if (start) begin
					x0_q <= sat_c(SW'(in_x0));
					y0_q <= sat_c(SW'(in_y0));
					x1_q <= sat_c(SW'(in_x1));
					y1_q <= sat_c(SW'(in_y1));
					pass_q <= '0;
				end
			end
			clr_pkg::CL_EVAL: begin
				sel0_q <= (c0 != clr_pkg::OC_NONE);
				use_y_q <= use_y;
				fixed_q <= fixed;
				base_q <= base;
				neg_q <= (a_v < 0) ^ (b_v < 0) ^ (den < 0);
				a_mag_q <= mag(a_v);
				b_mag_q <= mag(b_v);
				d_mag_q <= mag(den);
			end
			clr_pkg::CL_MUL: prod_q <= a_mag_q * b_mag_q;
			clr_pkg::CL_UPD: begin
				if (sel0_q) begin
					x0_q <= nx;
					y0_q <= ny;
				end else begin
					x1_q <= nx;
					y1_q <= ny;
				end
				pass_q <= pass_q + 5'd1;
			end
			default: ;
		endcase
	end

	assign cx0 = x0_q[clr_pkg::DIM_W-1:0];
	assign cy0 = y0_q[clr_pkg::DIM_W-1:0];
	assign cx1 = x1_q[clr_pkg::DIM_W-1:0];
	assign cy1 = y1_q[clr_pkg::DIM_W-1:0];

endmodule
`default_nettype wire

// ----- design/clipped_line_rasterizer_top.sv -----
`default_nettype none
// Clipped line rasterizer.
// Input words arrive on item_valid/item_ready; one result word per input
// word leaves on result_valid/result_ready through an output register.
// A start word (req_type 0) clips the segment against the screen and
// answers with visible; a step word (req_type 1) answers with the next
// pixel of the walk, its colour, depth and a last flag.
// Step words: result valid the cycle after acceptance; a new word is taken
// in the cycle the held result leaves: one word per cycle without stalls.
// Start words: each clip pass runs evaluate, multiply, divider launch, a
// 64-bit bit-serial divide with its done strobe, then update; a segment
// usually needs 0 to 4 passes (at most 16), and its result is registered
// when the final evaluation accepts or rejects it.
// Only one word is in flight; item_ready is low while clipping or while a
// result is held and the receiver stalls. Reset clears the walk and sets
// the screen to 640 by 480. The user writes screen_width (index 0) and
// screen_height (index 1) over cfg_we while idle, unenforced by the block.
module clipped_line_rasterizer_top #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [12:0]                   cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          req_type,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	input  wire logic [23:0]                   line_colour,
	input  wire logic signed [15:0]            depth_start,
	input  wire logic signed [15:0]            depth_end,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               visible,
	output logic                               pixel_valid,
	output logic [11:0]                        pixel_x,
	output logic [11:0]                        pixel_y,
	output logic [23:0]                        pixel_colour,
	output logic signed [15:0]                 pixel_depth,
	output logic                               last
);

	// coordinates saturate at 2^30; differences need one more bit
	localparam int CXW = 33;
	localparam int DW = clr_pkg::DIM_W;
	localparam int ZW = clr_pkg::DEC_W;

	clr_pkg::clr_state_t state_q, state_d;
	clr_pkg::clr_clip_res_t clip_res;
	clr_pkg::clr_mode_t mode_q, s_mode;

	logic [DW-1:0]  width_q, height_q, eff_w, eff_h;
	logic           walk_active_q;
	logic [DW-1:0]  cur_x_q, cur_y_q, steps_q;
	logic [DW-1:0]  dmaj_q, dmin_q;
	logic signed [ZW-1:0] dec_q;
	logic           negx_q, negy_q;
	logic [23:0]    colour_q;
	logic [15:0]    held_depth_q, z0_q, z1_q;
	logic           res_valid_q, res_vis_q, res_pv_q, res_last_q;
	logic [11:0]    res_x_q, res_y_q;
	logic [23:0]    res_col_q;
	logic [15:0]    res_z_q;

	logic           item_fire, clip_start;
	logic [DW-1:0]  cx0, cy0, cx1, cy1;
	logic [DW-1:0]  adx, ady, sx, sy, ex, ey, s_steps, s_maj, s_min;
	logic           s_swap, s_negx, s_negy, s_zsel;
	logic signed [ZW-1:0] s_dec;
	logic           in_screen;
	logic [DW-1:0]  nx, ny;
	logic signed [ZW-1:0] ndec;

	assign item_fire = item_valid && item_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= clr_pkg::WIDTH_RESET;
			height_q <= clr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clr_pkg::REG_WIDTH:  width_q <= cfg_data;
				clr_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = (width_q > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX : width_q;
	assign eff_h = (height_q > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX : height_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clr_pkg::ST_IDLE: if (item_fire && req_type == clr_pkg::REQ_START)
				state_d = clr_pkg::ST_CLIP;
			clr_pkg::ST_CLIP: if (clip_res.done) state_d = clr_pkg::ST_IDLE;
			default: state_d = clr_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		item_ready = 1'b0;
		clip_start = 1'b0;
		unique case (state_q)
			clr_pkg::ST_IDLE: begin
				item_ready = !res_valid_q || result_ready;
				clip_start = item_valid && item_ready && req_type == clr_pkg::REQ_START;
			end
			clr_pkg::ST_CLIP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= clr_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	clr_clip #(.CXW(CXW)) u_clip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clip_start),
		.in_x0  (CXW'(start_x)),
		.in_y0  (CXW'(start_y)),
		.in_x1  (CXW'(end_x)),
		.in_y1  (CXW'(end_y)),
		.dim_w  (eff_w),
		.dim_h  (eff_h),
		.res    (clip_res),
		.cx0    (cx0),
		.cy0    (cy0),
		.cx1    (cx1),
		.cy1    (cy1)
	);

	// walk setup from the clipped endpoints
	always_comb begin
		adx = (cx1 > cx0) ? cx1 - cx0 : cx0 - cx1;
		ady = (cy1 > cy0) ? cy1 - cy0 : cy0 - cy1;
		s_negx = 1'b0;
		s_negy = 1'b0;
		s_zsel = 1'b0;
		s_maj = '0;
		s_min = '0;
		s_dec = '0;
		s_swap = 1'b0;
		if (cy0 == cy1 || cx0 == cx1) begin
			s_swap = (cy0 == cy1) ? (cx0 > cx1) : (cy0 > cy1);
			s_zsel = s_swap;
			s_mode = (cy0 == cy1) ? clr_pkg::MODE_HORIZ : clr_pkg::MODE_VERT;
			s_steps = ((cy0 == cy1) ? adx : ady) + 1'b1;
		end else if (adx == ady) begin
			s_mode = clr_pkg::MODE_DIAG;
			s_negx = !(cx1 > cx0);
			s_negy = !(cy1 > cy0);
			s_steps = adx + 1'b1;
		end else if (ady < adx) begin
			s_swap = cx0 > cx1;
			s_mode = clr_pkg::MODE_XMAJOR;
			s_maj = adx;
			s_min = ady;
			s_dec = $signed({2'b0, ady, 1'b0}) - $signed(ZW'(adx));
			s_steps = adx + 1'b1;
		end else begin
			s_swap = cy0 > cy1;
			s_mode = clr_pkg::MODE_YMAJOR;
			s_maj = ady;
			s_min = adx;
			s_dec = $signed({2'b0, adx, 1'b0}) - $signed(ZW'(ady));
			s_steps = ady + 1'b1;
		end
		sx = s_swap ? cx1 : cx0;
		sy = s_swap ? cy1 : cy0;
		ex = s_swap ? cx0 : cx1;
		ey = s_swap ? cy0 : cy1;
		if (s_mode == clr_pkg::MODE_XMAJOR) s_negy = (sy >= ey);
		if (s_mode == clr_pkg::MODE_YMAJOR) s_negx = (sx >= ex);
	end

	// next cursor and decision term of the walk
	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		ndec = dec_q;
		case (mode_q)
			clr_pkg::MODE_XMAJOR: begin
				ndec = dec_q + $signed({2'b0, dmin_q, 1'b0});
				if (dec_q > 0) begin
					ny = negy_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
					ndec = ndec - $signed({2'b0, dmaj_q, 1'b0});
				end
				nx = cur_x_q + 1'b1;
			end
			clr_pkg::MODE_YMAJOR: begin
				ndec = dec_q + $signed({2'b0, dmin_q, 1'b0});
				if (dec_q > 0) begin
					nx = negx_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
					ndec = ndec - $signed({2'b0, dmaj_q, 1'b0});
				end
				ny = cur_y_q + 1'b1;
			end
			clr_pkg::MODE_HORIZ: nx = cur_x_q + 1'b1;
			clr_pkg::MODE_VERT:  ny = cur_y_q + 1'b1;
			default: begin
				nx = negx_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				ny = negy_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
		endcase
	end

	assign in_screen = (cur_x_q < eff_w) && (cur_y_q < eff_h);

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_active_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			steps_q <= '0;
			dec_q <= '0;
			dmaj_q <= '0;
			dmin_q <= '0;
			mode_q <= clr_pkg::MODE_HORIZ;
			negx_q <= 1'b0;
			negy_q <= 1'b0;
			colour_q <= '0;
			held_depth_q <= '0;
		end else if (item_fire && req_type == clr_pkg::REQ_START) begin
			walk_active_q <= 1'b0;
			colour_q <= line_colour;
		end else if (clip_res.done && clip_res.visible) begin
			walk_active_q <= 1'b1;
			cur_x_q <= sx;
			cur_y_q <= sy;
			steps_q <= s_steps;
			dec_q <= s_dec;
			dmaj_q <= s_maj;
			dmin_q <= s_min;
			mode_q <= s_mode;
			negx_q <= s_negx;
			negy_q <= s_negy;
			held_depth_q <= s_zsel ? z1_q : z0_q;
		end else if (item_fire && walk_active_q) begin
			steps_q <= steps_q - 1'b1;
			if (steps_q == DW'(1)) begin
				walk_active_q <= 1'b0;
			end else begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				dec_q <= ndec;
			end
		end
	end

	// endpoint depths held over the clip
	always_ff @(posedge clk) begin
		if (item_fire && req_type == clr_pkg::REQ_START) begin
			z0_q <= depth_start;
			z1_q <= depth_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (clip_res.done) begin
			res_valid_q <= 1'b1;
		end else if (item_fire && req_type == clr_pkg::REQ_STEP) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clip_res.done) begin
			res_vis_q <= clip_res.visible;
			res_pv_q <= 1'b0;
			res_x_q <= '0;
			res_y_q <= '0;
			res_col_q <= '0;
			res_z_q <= '0;
			res_last_q <= 1'b0;
		end else if (item_fire && req_type == clr_pkg::REQ_STEP) begin
			res_vis_q <= 1'b0;
			res_pv_q <= walk_active_q && in_screen;
			res_x_q <= (walk_active_q && in_screen) ? cur_x_q[11:0] : '0;
			res_y_q <= (walk_active_q && in_screen) ? cur_y_q[11:0] : '0;
			res_col_q <= (walk_active_q && in_screen) ? colour_q : '0;
			res_z_q <= (walk_active_q && in_screen) ? held_depth_q : '0;
			res_last_q <= walk_active_q && (steps_q == DW'(1));
		end
	end

	assign result_valid = res_valid_q;
	assign visible = res_vis_q;
	assign pixel_valid = res_pv_q;
	assign pixel_x = res_x_q;
	assign pixel_y = res_y_q;
	assign pixel_colour = res_col_q;
	assign pixel_depth = res_z_q;
	assign last = res_last_q;

`ifndef SYNTH
	// a clip result never lands on a held word
	a_clip_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		clip_res.done |-> !res_valid_q)
		else $error("clip result with output register full");

	// an active walk always has pixels left
	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		walk_active_q |-> (steps_q != '0))
		else $error("active walk with no steps left");

	// a visible start answer carries no pixel
	a_start_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_vis_q) |-> (!res_pv_q && !res_last_q))
		else $error("visible word carries pixel data");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_clipped_line_rasterizer_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_clipped_line_rasterizer_top;

	// one result word, field by field
	typedef struct packed {
		logic        visible;
		logic        pixel_valid;
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] colour;
		logic [15:0] depth;
		logic        last;
	} pixel_word_t;

	// line walk predictor plus queue of expected result words
	class raster_scoreboard;
		logic [12:0] width_reg = clr_pkg::WIDTH_RESET;
		logic [12:0] height_reg = clr_pkg::HEIGHT_RESET;
		bit walk_on;
		int cur_x, cur_y, err_term, pix_left, span_major, span_minor, step_x, step_y;
		clr_pkg::clr_mode_t mode = clr_pkg::MODE_HORIZ;
		logic [23:0] held_col;
		logic [15:0] held_z;
		pixel_word_t expected_q[$];
		int fails;

		function void set_reg(logic idx, logic [12:0] val);
			if (idx == clr_pkg::REG_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		function longint clamp_coord(longint v);
			if (v > 64'sd1073741824)
				return 64'sd1073741824;
			if (v < -64'sd1073741824)
				return -64'sd1073741824;
			return v;
		endfunction

		// single-bit region code, top wins over bottom over right over left
		function logic [3:0] region_code(longint x, longint y, longint w, longint h);
			if (y > h)
				return clr_pkg::OC_TOP;
			if (y < 0)
				return clr_pkg::OC_BOTTOM;
			if (x > w)
				return clr_pkg::OC_RIGHT;
			if (x < 0)
				return clr_pkg::OC_LEFT;
			return clr_pkg::OC_NONE;
		endfunction

		function bit clip_ends(ref longint x0, ref longint y0, ref longint x1, ref longint y1,
				input longint w, input longint h);
			logic [3:0] c0, c1, hit;
			longint nx, ny, den;
			c0 = region_code(x0, y0, w, h);
			c1 = region_code(x1, y1, w, h);
			for (int pass = 0; pass < clr_pkg::CLIP_PASSES; pass++) begin
				if (c0 == clr_pkg::OC_NONE && c1 == clr_pkg::OC_NONE)
					return 1;
				if ((c0 & c1) != 0)
					return 0;
				hit = (c0 != clr_pkg::OC_NONE) ? c0 : c1;
				if ((hit & (clr_pkg::OC_TOP | clr_pkg::OC_BOTTOM)) != 0) begin
					ny = (hit == clr_pkg::OC_TOP) ? h : 0;
					den = y1 - y0;
					if (den == 0)
						return 0;
					nx = x0 + ((x1 - x0) * (ny - y0)) / den;
				end else begin
					nx = (hit == clr_pkg::OC_RIGHT) ? w : 0;
					den = x1 - x0;
					if (den == 0)
						return 0;
					ny = y0 + ((y1 - y0) * (nx - x0)) / den;
				end
				nx = clamp_coord(nx);
				ny = clamp_coord(ny);
				if (hit == c0) begin
					x0 = nx;
					y0 = ny;
					c0 = region_code(nx, ny, w, h);
				end else begin
					x1 = nx;
					y1 = ny;
					c1 = region_code(nx, ny, w, h);
				end
			end
			return 0;
		endfunction

		function void begin_walk(int x0, int y0, int x1, int y1, logic [15:0] z0, logic [15:0] z1);
			int dx, dy, t;
			bit flat;
			dx = (x1 > x0) ? x1 - x0 : x0 - x1;
			dy = (y1 > y0) ? y1 - y0 : y0 - y1;
			held_z = z0;
			err_term = 0;
			span_major = 0;
			span_minor = 0;
			step_x = 0;
			step_y = 0;
			if (y0 == y1 || x0 == x1) begin
				flat = (y0 == y1);
				// straight lines always run toward increasing x or y; a swap carries the far depth
				if (flat ? (x0 > x1) : (y0 > y1)) begin
					t = x0; x0 = x1; x1 = t;
					t = y0; y0 = y1; y1 = t;
					held_z = z1;
				end
				mode = flat ? clr_pkg::MODE_HORIZ : clr_pkg::MODE_VERT;
				step_x = flat ? 1 : 0;
				step_y = flat ? 0 : 1;
				pix_left = (flat ? dx : dy) + 1;
			end else if (dx == dy) begin
				mode = clr_pkg::MODE_DIAG;
				step_x = (x1 > x0) ? 1 : -1;
				step_y = (y1 > y0) ? 1 : -1;
				pix_left = dx + 1;
			end else if (dy < dx) begin
				if (x0 > x1) begin
					t = x0; x0 = x1; x1 = t;
					t = y0; y0 = y1; y1 = t;
				end
				mode = clr_pkg::MODE_XMAJOR;
				step_y = (y0 >= y1) ? -1 : 1;
				span_major = dx;
				span_minor = dy;
				err_term = 2 * dy - dx;
				pix_left = dx + 1;
			end else begin
				if (y0 > y1) begin
					t = x0; x0 = x1; x1 = t;
					t = y0; y0 = y1; y1 = t;
				end
				mode = clr_pkg::MODE_YMAJOR;
				step_x = (x0 >= x1) ? -1 : 1;
				span_major = dy;
				span_minor = dx;
				err_term = 2 * dx - dy;
				pix_left = dy + 1;
			end
			cur_x = x0;
			cur_y = y0;
			walk_on = 1;
		endfunction

		function void advance_cursor();
			if (mode == clr_pkg::MODE_XMAJOR) begin
				if (err_term > 0) begin
					cur_y += step_y;
					err_term -= 2 * span_major;
				end
				err_term += 2 * span_minor;
				cur_x += 1;
			end else if (mode == clr_pkg::MODE_YMAJOR) begin
				if (err_term > 0) begin
					cur_x += step_x;
					err_term -= 2 * span_major;
				end
				err_term += 2 * span_minor;
				cur_y += 1;
			end else begin
				cur_x += step_x;
				cur_y += step_y;
			end
		endfunction

		function void note_input(logic rt, logic signed [15:0] sx, logic signed [15:0] sy,
				logic signed [15:0] ex, logic signed [15:0] ey, logic [23:0] col,
				logic [15:0] z0, logic [15:0] z1);
			pixel_word_t r;
			longint w, h, x0, y0, x1, y1;
			r = '0;
			w = (width_reg > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX : width_reg;
			h = (height_reg > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX : height_reg;
			if (rt == clr_pkg::REQ_START) begin
				walk_on = 0;
				held_col = col;
				x0 = sx; y0 = sy; x1 = ex; y1 = ey;
				if (clip_ends(x0, y0, x1, y1, w, h)) begin
					begin_walk(int'(x0), int'(y0), int'(x1), int'(y1), z0, z1);
					r.visible = 1;
				end
			end else if (walk_on) begin
				if (cur_x >= 0 && cur_x < w && cur_y >= 0 && cur_y < h) begin
					r.pixel_valid = 1;
					r.x = cur_x[11:0];
					r.y = cur_y[11:0];
					r.colour = held_col;
					r.depth = held_z;
				end
				pix_left -= 1;
				if (pix_left <= 0) begin
					r.last = 1;
					walk_on = 0;
					pix_left = 0;
				end else
					advance_cursor();
			end
			expected_q.push_back(r);
		endfunction

		function void field_check(string name, longint e, longint a);
			if (e != a) begin
				fails++;
				$display("%0t: %s mismatch, expected %0h got %0h", $time, name, e, a);
			end
		endfunction

		function void check_result(pixel_word_t got);
			pixel_word_t e;
			if (expected_q.size() == 0) begin
				fails++;
				$display("%0t: unexpected result word, expected none got %h", $time, got);
				return;
			end
			e = expected_q.pop_front();
			field_check("visible", e.visible, got.visible);
			field_check("pixel_valid", e.pixel_valid, got.pixel_valid);
			field_check("pixel_x", e.x, got.x);
			field_check("pixel_y", e.y, got.y);
			field_check("pixel_colour", e.colour, got.colour);
			field_check("pixel_depth", e.depth, got.depth);
			field_check("last", e.last, got.last);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = clr_pkg::REG_WIDTH;
	logic [12:0] cfg_data = '0;
	logic item_valid = 0;
	logic item_ready;
	logic req_type = clr_pkg::REQ_START;
	logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [23:0] line_colour = '0;
	logic signed [15:0] depth_start = '0, depth_end = '0;
	logic result_valid;
	logic result_ready = 0;
	logic visible, pixel_valid, last;
	logic [11:0] pixel_x, pixel_y;
	logic [23:0] pixel_colour;
	logic signed [15:0] pixel_depth;

	raster_scoreboard sb = new();
	bit no_idle;
	int words_sent;
	int hold_left;

	clipped_line_rasterizer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.req_type(req_type), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .line_colour(line_colour),
		.depth_start(depth_start), .depth_end(depth_end),
		.result_valid(result_valid), .result_ready(result_ready),
		.visible(visible), .pixel_valid(pixel_valid), .pixel_x(pixel_x),
		.pixel_y(pixel_y), .pixel_colour(pixel_colour), .pixel_depth(pixel_depth),
		.last(last)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// mostly short gaps, a few long ones; none while no_idle is set
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver side: random stalls, check every accepted result word
	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check_result({visible, pixel_valid, pixel_x, pixel_y, pixel_colour,
				pixel_depth, last});
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 0;
		end else begin
			hold_left <= pick_gap();
			result_ready <= 1;
		end
	end

	task automatic send_word(logic rt, logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] ex, logic signed [15:0] ey, logic [23:0] col,
			logic [15:0] z0, logic [15:0] z1);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		req_type <= rt;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		line_colour <= col;
		depth_start <= z0;
		depth_end <= z1;
		do @(posedge clk); while (!item_ready);
		sb.note_input(rt, sx, sy, ex, ey, col, z0, z1);
		words_sent++;
	endtask

	// step word with junk in the unused fields
	task automatic send_step();
		send_word(clr_pkg::REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic run_segment(int x0, int y0, int x1, int y1, logic [23:0] col,
			logic [15:0] z0, logic [15:0] z1, int max_steps, int extra);
		int n;
		n = 0;
		send_word(clr_pkg::REQ_START, 16'(x0), 16'(y0), 16'(x1), 16'(y1), col, z0, z1);
		while (sb.walk_on && n < max_steps) begin
			send_step();
			n++;
		end
		repeat (extra) send_step();
	endtask

	task automatic write_reg(logic idx, logic [12:0] val);
		item_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	function int near_coord(int dim);
		return $urandom_range(0, dim + 16) - 8;
	endfunction

	// random segment shaped to hit each walk mode and the clip paths
	task automatic random_segment();
		int w, h, x0, y0, x1, y1, d;
		w = int'((sb.width_reg > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX : sb.width_reg);
		h = int'((sb.height_reg > clr_pkg::SCREEN_MAX) ? clr_pkg::SCREEN_MAX
			: sb.height_reg);
		x0 = near_coord(w);
		y0 = near_coord(h);
		d = $urandom_range(0, 40) - 20;
		case ($urandom_range(0, 7))
			0: begin x1 = x0 + d; y1 = y0; end
			1: begin x1 = x0; y1 = y0 + d; end
			2: begin x1 = x0 + d; y1 = ($urandom_range(0, 1) == 1) ? y0 + d : y0 - d; end
			3, 4: begin
				x1 = x0 + $urandom_range(0, 40) - 20;
				y1 = y0 + $urandom_range(0, 40) - 20;
			end
			5: begin x1 = near_coord(w); y1 = near_coord(h); end
			default: begin
				x0 = int'($signed(16'($urandom)));
				y0 = int'($signed(16'($urandom)));
				x1 = int'($signed(16'($urandom)));
				y1 = int'($signed(16'($urandom)));
			end
		endcase
		run_segment(x0, y0, x1, y1, 24'($urandom), 16'($urandom), 16'($urandom),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 60, $urandom_range(0, 1));
	endtask

	initial begin
		int wset[$], hset[$], idx;
		wset = '{640, 4096, 1, 0, 8191, 37, 4096, 1, 200, 13};
		hset = '{480, 4096, 1, 0, 8191, 23, 1, 4096, 150, 4095};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset screen, each walk mode and clip case
		send_step();
		run_segment(12, 5, 9, 5, 24'hFFFFFF, 16'h7FFF, 16'h8000, 10, 0);
		run_segment(3, 9, 3, 6, 24'h000000, 16'h8000, 16'h7FFF, 10, 0);
		run_segment(2, 2, 5, 5, 24'h123456, 16'h0001, 16'h0002, 10, 0);
		run_segment(5, 2, 2, 5, 24'hABCDEF, 16'h0003, 16'h0004, 10, 0);
		run_segment(0, 0, 5, 2, 24'h00FF00, 16'h1111, 16'h2222, 10, 0);
		run_segment(1, 3, 0, 0, 24'hFF0000, 16'h3333, 16'h4444, 10, 0);
		run_segment(-5, -5, -1, -9, 24'h0000FF, 16'h5555, 16'h6666, 10, 1);
		run_segment(637, 479, 640, 479, 24'hFFFFFF, 16'hFFFF, 16'h0000, 10, 0);
		run_segment(-32768, -32768, 32767, 32767, 24'hFFFFFF, 16'h7FFF, 16'h8000, 3, 0);
		run_segment(10, 10, 10, 10, 24'h000000, 16'h0000, 16'hFFFF, 10, 1);

		// random phases across screen settings, extremes included
		idx = 0;
		while (words_sent < 580) begin
			write_reg(clr_pkg::REG_WIDTH, (idx < wset.size()) ? 13'(wset[idx])
				: 13'($urandom));
			write_reg(clr_pkg::REG_HEIGHT, (idx < hset.size()) ? 13'(hset[idx])
				: 13'($urandom));
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (12)
				if (words_sent < 580)
					random_segment();
			idx++;
		end
		item_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
